/* design/pol_pkg.sv */
// Package for the positional ordered list: sizes, command codes and cell control type.
`default_nettype none

package pol_pkg;

    // Number of cells in the row
    localparam int CAPACITY = 64;

    // Fixed field widths of the item interfaces
    localparam int CMD_W  = 3;
    localparam int POS_W  = 7;
    localparam int DATA_W = 8;

    // Internal widths derived from the capacity
    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int FILL_W = $clog2(CAPACITY + 1);
    // Compare width: wide enough for a position field and for the fill count
    localparam int CMP_W  = (FILL_W > POS_W) ? FILL_W : POS_W;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_DELETE = 3'd1,
        CMD_GET    = 3'd2,
        CMD_LOCATE = 3'd3,
        CMD_CLEAR  = 3'd4
    } cmd_e;

    // Control broadcast to every cell in the row
    typedef struct packed {
        logic              ins_en;   // insert at p0, shift higher cells up
        logic              del_en;   // remove at p0, shift higher cells down
        logic [CMP_W-1:0]  p0;       // zero-based target position
        logic [CMP_W-1:0]  fill;     // entry count before the command
        logic [DATA_W-1:0] value;    // byte to insert or to look for
    } cell_ctrl_t;

endpackage

`default_nettype wire

/* design/pol_if.sv */
// Item channel interfaces: command request and command result.
`default_nettype none

interface pol_req_if;
    import pol_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] item_value;

    modport source (output valid, cmd, position, item_value, input ready);
    modport sink   (input valid, cmd, position, item_value, output ready);
endinterface

interface pol_rsp_if;
    import pol_pkg::*;

    logic              valid;
    logic              ready;
    logic              ok;
    logic [DATA_W-1:0] read_value;
    logic [POS_W-1:0]  found_position;
    logic [POS_W-1:0]  count_now;
    logic              is_empty;

    modport source (output valid, ok, read_value, found_position, count_now, is_empty,
                    input ready);
    modport sink   (input valid, ok, read_value, found_position, count_now, is_empty,
                    output ready);
endinterface

`default_nettype wire

/* design/positional_ordered_list.sv */
// Top level of the positional ordered list.
`default_nettype none

// Positional ordered list of up to CAPACITY bytes, addressed by 1-based position.
// Each request item carries one command (insert, delete, get, locate, clear) and
// gives exactly one result item. The entries live in a row of cells; an insert or
// delete shifts every cell above the target position in the same clock, and a
// locate compares all live cells at once, so every command is done in one update
// of the row and its result is loaded into the output register. A new request is
// taken each cycle as long as the result register is empty or is being read;
// the sustained rate is one command per cycle while results are read, set by the
// update of the cell row. Unwritten cells are never read: only places below
// the count are live. After reset the list is empty and ready at once.

module positional_ordered_list
    import pol_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    pol_req_if.sink     req,
    pol_rsp_if.source   rsp
);

    logic              accept;
    logic [CMP_W-1:0]  pos_w;
    logic [CMP_W-1:0]  fill_w;
    logic              ins_ok;
    logic              rd_ok;
    cell_ctrl_t        ctrl;

    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;

    logic              out_valid_reg;
    logic              ok_reg;
    logic              ok_next;
    logic [DATA_W-1:0] read_reg;
    logic [DATA_W-1:0] read_next;
    logic [POS_W-1:0]  found_reg;
    logic [POS_W-1:0]  found_next;
    logic [POS_W-1:0]  count_reg;
    logic              empty_reg;

    logic [DATA_W-1:0]   cell_data  [CAPACITY];
    logic [DATA_W-1:0]   cell_sel   [CAPACITY];
    logic [CAPACITY-1:0] cell_match;
    logic [DATA_W-1:0]   sel_or;
    logic [FILL_W-1:0]   found_raw;
    logic [CMP_W-1:0]    found_w;
    logic [CMP_W-1:0]    fill_next_w;

    // Handshake: output register parts the two sides
    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    // Range checks
    assign pos_w  = CMP_W'(req.position);
    assign fill_w = CMP_W'(fill_reg);
    assign ins_ok = (pos_w != '0) && ((pos_w - CMP_W'(1)) <= fill_w)
                    && (fill_w < CMP_W'(CAPACITY));
    assign rd_ok  = (pos_w != '0) && (pos_w <= fill_w);

    // Control broadcast to the row
    always_comb
    begin
        ctrl.ins_en = accept && (req.cmd == CMD_INSERT) && ins_ok;
        ctrl.del_en = accept && (req.cmd == CMD_DELETE) && rd_ok;
        ctrl.p0     = pos_w - CMP_W'(1);
        ctrl.fill   = fill_w;
        ctrl.value  = req.item_value;
    end

    // Row of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_W-1:0] left_d;
        logic [DATA_W-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_left
            assign left_d = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_d = '0;
        end
        else
        begin : g_right
            assign right_d = cell_data[i+1];
        end

        pol_cell u_cell (
            .clk        (clk),
            .idx        (CMP_W'(i)),
            .ctrl       (ctrl),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .match      (cell_match[i]),
            .sel_data   (cell_sel[i])
        );
    end

    // Selected entry: at most one cell drives a nonzero value
    always_comb
    begin
        sel_or = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            sel_or = sel_or | cell_sel[k];
        end
    end

    pol_find u_find (
        .match (cell_match),
        .found (found_raw)
    );

    assign found_w = CMP_W'(found_raw);

    // Next count and result fields
    always_comb
    begin
        fill_next  = fill_reg;
        ok_next    = 1'b0;
        read_next  = '0;
        found_next = '0;
        case (req.cmd)
            CMD_INSERT:
            begin
                ok_next = ins_ok;
                if (ins_ok)
                    fill_next = fill_reg + FILL_W'(1);
            end
            CMD_DELETE:
            begin
                ok_next = rd_ok;
                if (rd_ok)
                begin
                    fill_next = fill_reg - FILL_W'(1);
                    read_next = sel_or;
                end
            end
            CMD_GET:
            begin
                ok_next = rd_ok;
                if (rd_ok)
                    read_next = sel_or;
            end
            CMD_LOCATE:
            begin
                ok_next    = 1'b1;
                found_next = found_w[POS_W-1:0];
            end
            CMD_CLEAR:
            begin
                ok_next   = 1'b1;
                fill_next = '0;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    assign fill_next_w = CMP_W'(fill_next);

    // Count and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                fill_reg      <= fill_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ok_reg    <= ok_next;
            read_reg  <= read_next;
            found_reg <= found_next;
            count_reg <= fill_next_w[POS_W-1:0];
            empty_reg <= (fill_next == '0);
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.ok             = ok_reg;
    assign rsp.read_value     = read_reg;
    assign rsp.found_position = found_reg;
    assign rsp.count_now      = count_reg;
    assign rsp.is_empty       = empty_reg;

endmodule

`default_nettype wire

/* design/pol_cell.sv */
// One list cell: holds one entry, shifts with its neighbors, matches and selects.
`default_nettype none

module pol_cell
    import pol_pkg::*;
(
    input  wire logic              clk,
    input  wire logic [CMP_W-1:0]  idx,        // zero-based place of this cell
    input  wire cell_ctrl_t        ctrl,
    input  wire logic [DATA_W-1:0] left_data,  // entry of the cell below
    input  wire logic [DATA_W-1:0] right_data, // entry of the cell above
    output logic [DATA_W-1:0]      data,
    output logic                   match,
    output logic [DATA_W-1:0]      sel_data
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              at_pos;
    logic              above_pos;

    assign at_pos    = (idx == ctrl.p0);
    assign above_pos = (idx > ctrl.p0);

    // Shift or load
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.ins_en)
        begin
            if (at_pos)
                data_next = ctrl.value;
            else if (above_pos)
                data_next = left_data;
        end
        else if (ctrl.del_en)
        begin
            if (at_pos || above_pos)
                data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    // Only cells below the fill count hold live entries
    assign match    = (idx < ctrl.fill) && (data_reg == ctrl.value);
    assign sel_data = at_pos ? data_reg : '0;

endmodule

`default_nettype wire

/* design/pol_find.sv */
// First-match finder over the row of cell match flags.
`default_nettype none

module pol_find
    import pol_pkg::*;
(
    input  wire logic [CAPACITY-1:0] match,
    output logic [FILL_W-1:0]        found  // 1-based place of first match, 0 if none
);

    logic [CAPACITY-1:0] first;

    // Isolate the lowest set flag
    assign first = match & (~match + CAPACITY'(1));

    // Encode the one-hot flag as a 1-based position
    always_comb
    begin
        found = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            if (first[k])
                found = found | FILL_W'(k + 1);
        end
    end

endmodule

`default_nettype wire

/* design/pol_check.sv */
// Port-level checker for the positional ordered list, bound to the top level.
`default_nettype none

module pol_check
    import pol_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              req_valid,
    input wire logic              req_ready,
    input wire logic [CMD_W-1:0]  req_cmd,
    input wire logic              rsp_valid,
    input wire logic              rsp_ready,
    input wire logic              rsp_ok,
    input wire logic [DATA_W-1:0] rsp_read_value,
    input wire logic [POS_W-1:0]  rsp_found_position,
    input wire logic [POS_W-1:0]  rsp_count_now,
    input wire logic              rsp_is_empty
);

    // Empty flag agrees with the count
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_is_empty == (rsp_count_now == '0)))
        else $error("is_empty disagrees with count_now");

    // Count never exceeds capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (CAPACITY > 127 || int'(rsp_count_now) <= CAPACITY))
        else $error("count_now above capacity");

    // A clear item gives an empty, successful result next cycle
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && req_cmd == CMD_CLEAR) |=>
            (rsp_valid && rsp_ok && rsp_is_empty))
        else $error("clear result wrong");

    // Found position stays within the list
    a_found: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && CAPACITY <= 127) |-> (rsp_found_position <= rsp_count_now))
        else $error("found_position beyond count");

    // Stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=>
            (rsp_valid && $stable(rsp_read_value) && $stable(rsp_count_now)))
        else $error("result changed while stalled");

endmodule

bind positional_ordered_list pol_check u_pol_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (req.valid),
    .req_ready          (req.ready),
    .req_cmd            (req.cmd),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_ok             (rsp.ok),
    .rsp_read_value     (rsp.read_value),
    .rsp_found_position (rsp.found_position),
    .rsp_count_now      (rsp.count_now),
    .rsp_is_empty       (rsp.is_empty)
);

`default_nettype wire
